// ----- src/ipv4v_pkg.sv -----
// ----------------------------------------------------------------------------
// ipv4v_pkg: shared types and constants for the IPv4 text validator
// Character codes, error codes, scan state and verdict structures.
// ----------------------------------------------------------------------------
package ipv4v_pkg;

    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam int unsigned OCTET_W   = 9;
    localparam int unsigned COUNT_W   = 3;
    localparam logic [OCTET_W-1:0] OCTET_MAX = 9'd255;
    localparam logic [OCTET_W-1:0] OCTET_SAT = 9'd256;
    localparam logic [COUNT_W-1:0] COUNT_SAT = 3'd7;
    localparam logic [COUNT_W-1:0] COUNT_ONE = 3'd1;
    localparam logic [COUNT_W-1:0] NUMBERS_NEEDED = 3'd4;

    typedef enum logic [2:0] {
        ERR_OK         = 3'd0,
        ERR_LEAD_DOT   = 3'd1,
        ERR_TRAIL_DOT  = 3'd2,
        ERR_FOREIGN    = 3'd3,
        ERR_LEAD_ZERO  = 3'd4,
        ERR_RANGE      = 3'd5,
        ERR_DOUBLE_DOT = 3'd6,
        ERR_COUNT      = 3'd7
    } err_code_t;

    typedef struct packed {
        logic                 at_string_start;
        logic                 began_with_dot;
        logic [OCTET_W-1:0]   octet_accum;
        logic                 after_dot;
        logic                 zero_lead_pending;
        logic [COUNT_W-1:0]   number_count;
        err_code_t            first_scan_error;
    } scan_state_t;

    typedef struct packed {
        logic      is_valid;
        err_code_t error_code;
    } verdict_t;

    localparam scan_state_t SCAN_RESET = '{
        at_string_start:   1'b1,
        began_with_dot:    1'b0,
        octet_accum:       '0,
        after_dot:         1'b0,
        zero_lead_pending: 1'b0,
        number_count:      COUNT_ONE,
        first_scan_error:  ERR_OK
    };

endpackage

// ----- src/ipv4v_scan.sv -----
// ----------------------------------------------------------------------------
// ipv4v_scan: per-character scan step
// Computes the next scan state for one character and, on the last
// character of a string, the verdict.
// ----------------------------------------------------------------------------
module ipv4v_scan (
    input  ipv4v_pkg::scan_state_t state_cur,
    input  logic [7:0]             char_in,
    input  logic                   is_last,
    output ipv4v_pkg::scan_state_t state_next,
    output ipv4v_pkg::verdict_t    verdict
);

    logic                              is_digit;
    logic                              is_dot;
    logic                              first;
    logic [3:0]                        digit;
    logic [12:0]                       product;
    logic [ipv4v_pkg::OCTET_W-1:0]     accum_sat;
    ipv4v_pkg::scan_state_t            scanned;
    ipv4v_pkg::err_code_t              final_err;
    ipv4v_pkg::err_code_t              code;

    assign is_digit = (char_in >= ipv4v_pkg::CHAR_ZERO) && (char_in <= ipv4v_pkg::CHAR_NINE);
    assign is_dot   = (char_in == ipv4v_pkg::CHAR_DOT);
    assign first    = state_cur.at_string_start;
    assign digit    = 4'(char_in - ipv4v_pkg::CHAR_ZERO);

    // accum * 10 + digit as shift-and-add; the accumulator never exceeds 256.
    assign product = {1'b0, state_cur.octet_accum, 3'b000}
                   + {3'b000, state_cur.octet_accum, 1'b0}
                   + {9'd0, digit};
    assign accum_sat = (product > 13'(ipv4v_pkg::OCTET_MAX))
                     ? ipv4v_pkg::OCTET_SAT : product[ipv4v_pkg::OCTET_W-1:0];

    always_comb
    begin
        scanned = state_cur;
        scanned.at_string_start = 1'b0;
        if (first)
        begin
            scanned.began_with_dot = is_dot;
        end
        if (state_cur.first_scan_error == ipv4v_pkg::ERR_OK)
        begin
            if (first && (char_in == ipv4v_pkg::CHAR_ZERO))
            begin
                scanned.zero_lead_pending = 1'b1;
                scanned.octet_accum       = '0;
            end
            else if (!is_digit && !is_dot)
            begin
                scanned.first_scan_error = ipv4v_pkg::ERR_FOREIGN;
            end
            else if (is_digit)
            begin
                if (state_cur.zero_lead_pending)
                begin
                    scanned.first_scan_error = ipv4v_pkg::ERR_LEAD_ZERO;
                end
                else
                begin
                    if ((char_in == ipv4v_pkg::CHAR_ZERO) && state_cur.after_dot)
                    begin
                        scanned.zero_lead_pending = 1'b1;
                    end
                    scanned.after_dot   = 1'b0;
                    scanned.octet_accum = accum_sat;
                end
            end
            else
            begin
                scanned.zero_lead_pending = 1'b0;
                if (state_cur.after_dot)
                begin
                    scanned.first_scan_error = ipv4v_pkg::ERR_DOUBLE_DOT;
                end
                else
                begin
                    scanned.after_dot = 1'b1;
                    if (state_cur.octet_accum > ipv4v_pkg::OCTET_MAX)
                    begin
                        scanned.first_scan_error = ipv4v_pkg::ERR_RANGE;
                    end
                    else
                    begin
                        if (state_cur.number_count < ipv4v_pkg::COUNT_SAT)
                        begin
                            scanned.number_count = state_cur.number_count + 3'd1;
                        end
                        scanned.octet_accum = '0;
                    end
                end
            end
        end
    end

    // The final number gets the same range check as the ones ended by a dot.
    assign final_err = ((scanned.first_scan_error == ipv4v_pkg::ERR_OK)
                        && (scanned.octet_accum > ipv4v_pkg::OCTET_MAX))
                     ? ipv4v_pkg::ERR_RANGE : scanned.first_scan_error;

    always_comb
    begin
        if (scanned.began_with_dot)
        begin
            code = ipv4v_pkg::ERR_LEAD_DOT;
        end
        else if (is_dot)
        begin
            code = ipv4v_pkg::ERR_TRAIL_DOT;
        end
        else if (final_err != ipv4v_pkg::ERR_OK)
        begin
            code = final_err;
        end
        else if (scanned.number_count != ipv4v_pkg::NUMBERS_NEEDED)
        begin
            code = ipv4v_pkg::ERR_COUNT;
        end
        else
        begin
            code = ipv4v_pkg::ERR_OK;
        end
    end

    assign verdict.is_valid   = (code == ipv4v_pkg::ERR_OK);
    assign verdict.error_code = code;
    assign state_next         = is_last ? ipv4v_pkg::SCAN_RESET : scanned;

endmodule

// ----- src/ipv4v_out_queue.sv -----
// ----------------------------------------------------------------------------
// ipv4v_out_queue: two-entry result queue
// Holds verdicts until the downstream side takes them, so the input side
// keeps moving while a result waits.
// ----------------------------------------------------------------------------
module ipv4v_out_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ipv4v_pkg::verdict_t push_data,
    output logic                has_room,
    output logic                out_valid,
    input  logic                out_ready,
    output ipv4v_pkg::verdict_t head
);

    ipv4v_pkg::verdict_t entry_reg [2];
    logic                wr_ptr_reg;
    logic                wr_ptr_next;
    logic                rd_ptr_reg;
    logic                rd_ptr_next;
    logic [1:0]          count_reg;
    logic [1:0]          count_next;
    logic                pop;

    assign out_valid = (count_reg != 2'd0);
    assign has_room  = (count_reg != 2'd2);
    assign head      = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- src/ipv4_text_validator.sv -----
// ----------------------------------------------------------------------------
// ipv4_text_validator: streaming dotted-decimal IPv4 address checker
// The verdict of a string's last beat is registered in the result queue before it is offered.
// Throughput: one character beat per cycle, sustained across strings while the result queue has room.
// Reset clears the scan state to the start of a string and empties the
// result queue; no result is pending after reset.
// ----------------------------------------------------------------------------
//
// Each accepted beat carries one ASCII character. The scan state (running
// octet value, number count, dot and leading-zero flags, first scan error)
// is computed by ipv4v_scan and registered on each accepted beat. On the beat flagged is_last
// the verdict is pushed into a two-entry queue and the scan state returns
// to its reset value, so the next beat starts a new string.
//
// The queue decouples the two sides: input beats keep flowing while a
// verdict waits, and in_ready drops only when both queue entries are full.
// Beats that are not the last of a string produce no result.
module ipv4_text_validator (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_in,
    input  logic       is_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       is_valid,
    output logic [2:0] error_code
);

    ipv4v_pkg::scan_state_t state_reg;
    ipv4v_pkg::scan_state_t state_next;
    ipv4v_pkg::verdict_t    verdict;
    ipv4v_pkg::verdict_t    head;
    logic                   accept;
    logic                   has_room;

    assign in_ready = has_room;
    assign accept   = in_valid && in_ready;

    ipv4v_scan u_scan (
        .state_cur  (state_reg),
        .char_in    (char_in),
        .is_last    (is_last),
        .state_next (state_next),
        .verdict    (verdict)
    );

    // The scan state only advances on an accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ipv4v_pkg::SCAN_RESET;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    ipv4v_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && is_last),
        .push_data (verdict),
        .has_room  (has_room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign is_valid   = head.is_valid;
    assign error_code = head.error_code;

endmodule

// ----- src/ipv4v_checker.sv -----
// ----------------------------------------------------------------------------
// ipv4v_checker: port-level assertions for the IPv4 text validator
// Watches the top-level ports and is bound to every instance.
// ----------------------------------------------------------------------------
module ipv4v_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       is_last,
    input logic       out_valid,
    input logic       out_ready,
    input logic       is_valid,
    input logic [2:0] error_code
);

    // A verdict is valid exactly when it carries no error code.
    a_valid_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_valid == (error_code == ipv4v_pkg::ERR_OK)))
        else $error("is_valid disagrees with error_code");

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(is_valid)
                                       && $stable(error_code)))
        else $error("stalled result beat changed");

    // With nothing queued, the last character yields a result next cycle.
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid && in_valid && in_ready && is_last) |=> out_valid)
        else $error("no result after the last character");

    // With nothing queued, a character that is not last yields no result.
    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid && !(in_valid && in_ready && is_last)) |=> !out_valid)
        else $error("result appeared without a last character");

    // An empty result queue never blocks the input side.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty result queue");

endmodule

bind ipv4_text_validator ipv4v_checker u_ipv4v_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .is_last    (is_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .is_valid   (is_valid),
    .error_code (error_code)
);

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking testbench for ipv4_text_validator
// Streams address strings into the validator one character beat at a time.
// A table of hand-picked strings comes first, then random strings. Most are
// well-formed quads and the rest are broken or noise. A scan model in the bench predicts
// each verdict that the table does not give, and every verdict beat is checked in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int DIRECTED_ROWS   = 24;
    localparam int BEATS_PER_PHASE = 540;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int MAX_REPORTS     = 10;

    // One row of the directed table. A row may patch one character, so that
    // bytes a string literal cannot carry (such as 8'h00) reach the block.
    // When typed is set, the verdict is taken from the row itself.
    typedef struct {
        string                text;
        int                   fix_pos;
        logic [7:0]           fix_char;
        bit                   typed;
        ipv4v_pkg::err_code_t code;
    } directed_row_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic [7:0] char_in    = 8'h00;
    logic       is_last    = 1'b0;
    logic       out_ready  = 1'b0;
    wire        in_ready;
    wire        out_valid;
    wire        is_valid;
    wire  [2:0] error_code;

    // Idle rates of the sender and the receiver, in percent.
    int send_idle_pct = 21;
    int recv_idle_pct = 47;

    // Verdicts that the block still owes, oldest first.
    ipv4v_pkg::verdict_t verdict_q[$];

    // Characters of the string about to be sent.
    logic [7:0] text_q[$];

    int cycle_count      = 0;
    int beats_sent       = 0;
    int strings_sent     = 0;
    int directed_beats   = 0;
    int verdicts_checked = 0;
    int mismatches       = 0;
    int code_seen [8];

    // Scan model state: the same bookkeeping the block keeps per string.
    logic                          m_fresh;
    logic                          m_lead_dot;
    logic [ipv4v_pkg::OCTET_W-1:0] m_value;
    logic                          m_dot_prev;
    logic                          m_zero_lead;
    logic [ipv4v_pkg::COUNT_W-1:0] m_count;
    ipv4v_pkg::err_code_t          m_scan_err;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{"0.0.0.0",           -1, 8'h00, 1'b1, ipv4v_pkg::ERR_OK},
        '{"255.255.255.255",   -1, 8'h00, 1'b1, ipv4v_pkg::ERR_OK},
        '{"1.2.3.4",           -1, 8'h00, 1'b1, ipv4v_pkg::ERR_OK},
        '{".1.2.3",            -1, 8'h00, 1'b1, ipv4v_pkg::ERR_LEAD_DOT},
        '{"1.2.3.",            -1, 8'h00, 1'b1, ipv4v_pkg::ERR_TRAIL_DOT},
        '{".",                 -1, 8'h00, 1'b1, ipv4v_pkg::ERR_LEAD_DOT},
        '{"..",                -1, 8'h00, 1'b1, ipv4v_pkg::ERR_LEAD_DOT},
        '{"1.2.3.4",            0, 8'h00, 1'b1, ipv4v_pkg::ERR_FOREIGN},
        '{"1.2.3.4",            6, 8'hFF, 1'b1, ipv4v_pkg::ERR_FOREIGN},
        '{"1.2.x.4.",          -1, 8'h00, 1'b1, ipv4v_pkg::ERR_TRAIL_DOT},
        '{"01.2.3.4",          -1, 8'h00, 1'b1, ipv4v_pkg::ERR_LEAD_ZERO},
        '{"1.02.3.4",          -1, 8'h00, 1'b1, ipv4v_pkg::ERR_LEAD_ZERO},
        '{"256.1.1.1",         -1, 8'h00, 1'b1, ipv4v_pkg::ERR_RANGE},
        '{"1.1.1.256",         -1, 8'h00, 1'b1, ipv4v_pkg::ERR_RANGE},
        '{"1.1.1.99999",       -1, 8'h00, 1'b1, ipv4v_pkg::ERR_RANGE},
        '{"1..2.3",            -1, 8'h00, 1'b1, ipv4v_pkg::ERR_DOUBLE_DOT},
        '{"1.2.3",             -1, 8'h00, 1'b1, ipv4v_pkg::ERR_COUNT},
        '{"1.2.3.4.5",         -1, 8'h00, 1'b1, ipv4v_pkg::ERR_COUNT},
        '{"1.2.3.4.5.6.7.8.9", -1, 8'h00, 1'b0, ipv4v_pkg::ERR_OK},
        '{"0",                 -1, 8'h00, 1'b0, ipv4v_pkg::ERR_OK},
        '{"9",                 -1, 8'h00, 1'b0, ipv4v_pkg::ERR_OK},
        '{"00",                -1, 8'h00, 1'b0, ipv4v_pkg::ERR_OK},
        '{"1.2.3.0",           -1, 8'h00, 1'b0, ipv4v_pkg::ERR_OK},
        '{"0.10.100.200",      -1, 8'h00, 1'b0, ipv4v_pkg::ERR_OK}
    };

    ipv4_text_validator i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_in    (char_in),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .is_valid   (is_valid),
        .error_code (error_code)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Scan model
    // ------------------------------------------------------------------------

    function automatic void clear_scan();
        m_fresh     = 1'b1;
        m_lead_dot  = 1'b0;
        m_value     = '0;
        m_dot_prev  = 1'b0;
        m_zero_lead = 1'b0;
        m_count     = ipv4v_pkg::COUNT_ONE;
        m_scan_err  = ipv4v_pkg::ERR_OK;
    endfunction

    // Advances the model by one accepted character. Returns 1 and fills in
    // the verdict when the character closes a string.
    function automatic bit scan_beat(input logic [7:0] ch, input logic last,
                                     output ipv4v_pkg::verdict_t verdict);
        logic                 digit;
        logic                 dot;
        logic                 first;
        int unsigned          next_value;
        ipv4v_pkg::err_code_t code;

        verdict = '0;
        digit   = (ch >= ipv4v_pkg::CHAR_ZERO) && (ch <= ipv4v_pkg::CHAR_NINE);
        dot     = (ch == ipv4v_pkg::CHAR_DOT);
        first   = m_fresh;
        if (first)
        begin
            m_lead_dot = dot;
        end

        // Once a scan error is latched the number, count and flags freeze.
        if (m_scan_err == ipv4v_pkg::ERR_OK)
        begin
            if (first && ch == ipv4v_pkg::CHAR_ZERO)
            begin
                // A zero that opens the string may not be followed by a digit.
                m_zero_lead = 1'b1;
                m_value     = '0;
            end
            else if (!digit && !dot)
            begin
                m_scan_err = ipv4v_pkg::ERR_FOREIGN;
            end
            else if (digit)
            begin
                if (m_zero_lead)
                begin
                    m_scan_err = ipv4v_pkg::ERR_LEAD_ZERO;
                end
                else
                begin
                    if (ch == ipv4v_pkg::CHAR_ZERO && m_dot_prev)
                    begin
                        m_zero_lead = 1'b1;
                    end
                    m_dot_prev = 1'b0;
                    next_value = m_value * 10 + (ch - ipv4v_pkg::CHAR_ZERO);
                    m_value    = (next_value > ipv4v_pkg::OCTET_MAX)
                               ? ipv4v_pkg::OCTET_SAT
                               : next_value[ipv4v_pkg::OCTET_W-1:0];
                end
            end
            else
            begin
                m_zero_lead = 1'b0;
                if (m_dot_prev)
                begin
                    m_scan_err = ipv4v_pkg::ERR_DOUBLE_DOT;
                end
                else
                begin
                    m_dot_prev = 1'b1;
                    if (m_value > ipv4v_pkg::OCTET_MAX)
                    begin
                        m_scan_err = ipv4v_pkg::ERR_RANGE;
                    end
                    else
                    begin
                        if (m_count < ipv4v_pkg::COUNT_SAT)
                        begin
                            m_count = m_count + 1'b1;
                        end
                        m_value = '0;
                    end
                end
            end
        end
        m_fresh = 1'b0;

        if (!last)
        begin
            return 1'b0;
        end

        // The number that ends the string gets the same range check.
        if (m_scan_err == ipv4v_pkg::ERR_OK && m_value > ipv4v_pkg::OCTET_MAX)
        begin
            m_scan_err = ipv4v_pkg::ERR_RANGE;
        end

        if (m_lead_dot)
        begin
            code = ipv4v_pkg::ERR_LEAD_DOT;
        end
        else if (dot)
        begin
            code = ipv4v_pkg::ERR_TRAIL_DOT;
        end
        else if (m_scan_err != ipv4v_pkg::ERR_OK)
        begin
            code = m_scan_err;
        end
        else if (m_count != ipv4v_pkg::NUMBERS_NEEDED)
        begin
            code = ipv4v_pkg::ERR_COUNT;
        end
        else
        begin
            code = ipv4v_pkg::ERR_OK;
        end

        verdict.is_valid   = (code == ipv4v_pkg::ERR_OK);
        verdict.error_code = code;
        clear_scan();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // String generation
    // ------------------------------------------------------------------------

    function automatic logic [7:0] foreign_char();
        logic [7:0] c;

        c = 8'($urandom_range(0, 255));
        while ((c >= ipv4v_pkg::CHAR_ZERO && c <= ipv4v_pkg::CHAR_NINE)
               || c == ipv4v_pkg::CHAR_DOT)
        begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    function automatic void push_number(input int unsigned value);
        string digits;

        digits = $sformatf("%0d", value);
        for (int i = 0; i < digits.len(); i++)
        begin
            text_q.push_back(digits[i]);
        end
    endfunction

    // Octets lean toward one, two and three digit values and the top value.
    function automatic int unsigned pick_octet();
        case ($urandom_range(0, 4))
            0:       return $urandom_range(0, 9);
            1:       return $urandom_range(10, 99);
            2:       return $urandom_range(100, 255);
            3:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // Fills text_q with one random string. About six in ten are well-formed
    // quads, one in ten is pure noise, and the rest carry one or two defects each.
    function automatic void build_random();
        int          kind;
        int          numbers;
        int          big_slot;
        int          len;
        int          pos;
        int unsigned value;

        text_q.delete();
        kind = $urandom_range(0, 99);

        if (kind < 10)
        begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
            begin
                case ($urandom_range(0, 2))
                    0:       text_q.push_back(8'(ipv4v_pkg::CHAR_ZERO + $urandom_range(0, 9)));
                    1:       text_q.push_back(ipv4v_pkg::CHAR_DOT);
                    default: text_q.push_back(foreign_char());
                endcase
            end
            return;
        end

        numbers = 4;
        if (kind >= 70 && kind < 80)
        begin
            numbers = $urandom_range(1, 7);
            if (numbers >= 4)
            begin
                numbers = numbers + 1;
            end
        end
        big_slot = (kind >= 80 && kind < 86) ? $urandom_range(0, numbers - 1) : -1;

        for (int i = 0; i < numbers; i++)
        begin
            if (i > 0)
            begin
                text_q.push_back(ipv4v_pkg::CHAR_DOT);
            end
            if (i == big_slot)
            begin
                value = $urandom_range(0, 1) ? $urandom_range(256, 999)
                                             : $urandom_range(1000, 99999);
            end
            else
            begin
                value = pick_octet();
            end
            push_number(value);
        end

        pos = $urandom_range(0, text_q.size() - 1);
        if (kind >= 86 && kind < 90)
        begin
            // Put a zero in front of some number.
            while (pos > 0 && text_q[pos-1] != ipv4v_pkg::CHAR_DOT)
            begin
                pos--;
            end
            text_q.insert(pos, ipv4v_pkg::CHAR_ZERO);
        end
        else if (kind >= 90 && kind < 94)
        begin
            text_q.insert(pos, ipv4v_pkg::CHAR_DOT);
        end
        else if (kind >= 94 && kind < 97)
        begin
            text_q[pos] = foreign_char();
        end
        else if (kind == 97)
        begin
            text_q.push_front(ipv4v_pkg::CHAR_DOT);
        end
        else if (kind == 98)
        begin
            text_q.push_back(ipv4v_pkg::CHAR_DOT);
        end
        else if (kind == 99)
        begin
            text_q.push_front(ipv4v_pkg::CHAR_DOT);
            text_q.push_back(ipv4v_pkg::CHAR_DOT);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Offers one character beat and waits for it to be taken. The expected
    // verdict is queued at the edge that accepts the closing beat, before the block
    // can offer it.
    task automatic send_beat(input logic [7:0] ch, input logic last,
                             input bit typed, input ipv4v_pkg::err_code_t code);
        ipv4v_pkg::verdict_t predicted;

        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        char_in  <= ch;
        is_last  <= last;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        beats_sent++;

        if (scan_beat(ch, last, predicted))
        begin
            if (typed)
            begin
                predicted.is_valid   = (code == ipv4v_pkg::ERR_OK);
                predicted.error_code = code;
            end
            verdict_q.push_back(predicted);
        end
    endtask

    task automatic send_text(input bit typed, input ipv4v_pkg::err_code_t code);
        for (int i = 0; i < text_q.size(); i++)
        begin
            send_beat(text_q[i], i == text_q.size() - 1, typed, code);
        end
        strings_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Outputs are read at the edge, so they hold the values the block drove
    // during the cycle that ends there.
    always @(posedge clk)
    begin
        ipv4v_pkg::verdict_t want;

        if (rst_n && out_valid && out_ready)
        begin
            if (verdict_q.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                begin
                    $display("cycle %0d: verdict valid=%0b code=%0d with none expected",
                             cycle_count, is_valid, error_code);
                end
                mismatches++;
            end
            else
            begin
                want = verdict_q.pop_front();
                verdicts_checked++;
                code_seen[want.error_code]++;
                if (is_valid !== want.is_valid || error_code !== want.error_code)
                begin
                    if (mismatches < MAX_REPORTS)
                    begin
                        $display("cycle %0d: expected valid=%0b code=%0d, %s",
                                 cycle_count, want.is_valid, want.error_code,
                                 $sformatf("got valid=%0b code=%0d",
                                           is_valid, error_code));
                    end
                    mismatches++;
                end
            end
        end
    end

    // Guard against a block that stops accepting or answering.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d verdicts outstanding",
                     cycle_count, verdict_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        int phase_start;

        clear_scan();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed strings: extremes, every error code and the corner cases.
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            text_q.delete();
            for (int i = 0; i < directed_rows[r].text.len(); i++)
            begin
                text_q.push_back(directed_rows[r].text[i]);
            end
            if (directed_rows[r].fix_pos >= 0)
            begin
                text_q[directed_rows[r].fix_pos] = directed_rows[r].fix_char;
            end
            send_text(directed_rows[r].typed, directed_rows[r].code);
        end
        directed_beats = beats_sent;

        // Random strings in three idle patterns: sender lighter, receiver
        // lighter, then back-to-back on both sides.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 21;
                    recv_idle_pct = 47;
                end
                1:
                begin
                    send_idle_pct = 47;
                    recv_idle_pct = 21;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_start = beats_sent;
            while (beats_sent - phase_start < BEATS_PER_PHASE)
            begin
                build_random();
                send_text(1'b0, ipv4v_pkg::ERR_OK);
            end
        end
        in_valid <= 1'b0;

        while (verdict_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d strings in %0d beats (%0d directed), checked %0d verdicts.",
                 strings_sent, beats_sent, directed_beats, verdicts_checked);
        $display("Verdict codes ok/lead/trail/foreign: %0d %0d %0d %0d",
                 code_seen[0], code_seen[1], code_seen[2], code_seen[3]);
        $display("Verdict codes zero/range/double/count: %0d %0d %0d %0d",
                 code_seen[4], code_seen[5], code_seen[6], code_seen[7]);
        if (mismatches == 0 && verdict_q.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/ipv4v_pkg.sv
src/ipv4v_scan.sv
src/ipv4v_out_queue.sv
src/ipv4_text_validator.sv
src/ipv4v_checker.sv
verif/tb.sv
